// ===== rtl/vau_pkg.sv =====
// Shared types, constants and helpers of the three-component vector unit.
package vau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int WIDE_W    = PROD_W + 2;

	// fixed-point image of 0.00001, rounded to nearest
	localparam logic [DATA_W-1:0] EPS_Q = DATA_W'(((1 << FRAC_BITS) + 50000) / 100000);

	localparam int SQ_STEPS  = DATA_W;
	localparam int SQ_STG    = SQ_STEPS / 2;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int DIV_STG   = (DIV_STEPS + 1) / 2;

	localparam logic [3:0] MODE_ADD   = 4'd0;
	localparam logic [3:0] MODE_SUB   = 4'd1;
	localparam logic [3:0] MODE_MUL   = 4'd2;
	localparam logic [3:0] MODE_SCALE = 4'd3;
	localparam logic [3:0] MODE_DOT   = 4'd4;
	localparam logic [3:0] MODE_CROSS = 4'd5;
	localparam logic [3:0] MODE_LEN   = 4'd6;
	localparam logic [3:0] MODE_NORM  = 4'd7;
	localparam logic [3:0] MODE_RAY   = 4'd8;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX =
		{{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] WIDE_MIN =
		{{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_DONE,
		KIND_LEN,
		KIND_NORM
	} kind_t;

	typedef struct packed {
		logic [3:0]               mode;
		logic signed [DATA_W-1:0] a_x;
		logic signed [DATA_W-1:0] a_y;
		logic signed [DATA_W-1:0] a_z;
		logic signed [DATA_W-1:0] b_x;
		logic signed [DATA_W-1:0] b_y;
		logic signed [DATA_W-1:0] b_z;
		logic signed [DATA_W-1:0] scalar_in;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_x;
		logic signed [DATA_W-1:0] res_y;
		logic signed [DATA_W-1:0] res_z;
		logic signed [DATA_W-1:0] res_scalar;
		logic                     saturated;
	} out_word_t;

	// word in flight through the root stages
	typedef struct packed {
		kind_t                   kind;
		out_word_t               res;
		logic [2:0]              neg;
		logic [2:0][DATA_W-1:0]  mag;
		logic [PROD_W-1:0]       rem;
		logic [PROD_W-1:0]       root;
	} sq_t;

	// word in flight through the divide stages
	typedef struct packed {
		kind_t                    kind;
		out_word_t                res;
		logic [2:0]               neg;
		logic [DATA_W-1:0]        len;
		logic [2:0][DATA_W:0]     rem;
		logic [2:0][FRAC_BITS:0]  quo;
	} dv_t;

	// clamp to the signed data range; top bit flags a clamp
	function automatic logic [DATA_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic [DATA_W:0] r;
		if (v > WIDE_MAX) begin
			r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < WIDE_MIN) begin
			r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/vector3_arithmetic_unit.sv =====
// Vector unit: add, sub, mul, scale, dot, cross, length, normalize and ray point
// in signed Q16.16.
//
// Command channel cmd (cmd_valid/cmd_ready) carries one word: mode, vectors a
// and b, and scalar_in. Response channel rsp (rsp_valid/rsp_ready) returns one
// word per command, in order: res_x/res_y/res_z, res_scalar and saturated.
// From accept to rsp_valid a word passes three front stages (products, sums,
// clamping), sixteen square-root stages of two root bits each, nine divide
// stages of up to two quotient bits each, and the output register.
// Throughput is one word per cycle while the receiver does not stall; every
// stage is a register that advances on one common enable.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and cmd_ready drops; no word is lost or repeated and the held response stays
// unchanged. Reset clears all valid bits, so the pipeline comes up empty and
// ready.
module vector3_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  vau_pkg::in_word_t  cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output vau_pkg::out_word_t rsp
);
	import vau_pkg::*;

	logic en;
	logic fr_vld;
	sq_t  fr;
	logic sq_vld;
	sq_t  sq;

	// advance unless a response waits unaccepted
	assign en        = !rsp_valid || rsp_ready;
	assign cmd_ready = en;

	vau_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cmd_vld (cmd_valid),
		.cmd     (cmd),
		.fr_vld  (fr_vld),
		.fr      (fr)
	);

	vau_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.din_vld  (fr_vld),
		.din      (fr),
		.dout_vld (sq_vld),
		.dout     (sq)
	);

	vau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.din_vld  (sq_vld),
		.din      (sq),
		.dout_vld (rsp_valid),
		.dout     (rsp)
	);

	localparam logic [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.saturated |->
			rsp.res_x == D_MAX || rsp.res_x == D_MIN ||
			rsp.res_y == D_MAX || rsp.res_y == D_MIN ||
			rsp.res_z == D_MAX || rsp.res_z == D_MIN ||
			rsp.res_scalar == D_MAX || rsp.res_scalar == D_MIN)
		else $error("saturated raised without a clamped field");

	a_scalar_or_vector: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.res_scalar == '0 ||
			(rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0))
		else $error("scalar and vector result both non-zero");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld && rsp_valid && !rsp_ready |=> sq_vld && rsp_valid && $stable(rsp))
		else $error("pipeline advanced while response stalled");

endmodule

// ===== rtl/vau_front.sv =====
// Operand selection, products, sums and clamping of the vector unit.
module vau_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             cmd_vld,
	input  vau_pkg::in_word_t cmd,
	output logic             fr_vld,
	output vau_pkg::sq_t     fr
);
	import vau_pkg::*;

	logic signed [DATA_W-1:0] av [3];
	logic signed [DATA_W-1:0] bv [3];
	logic signed [DATA_W-1:0] m0a [3];
	logic signed [DATA_W-1:0] m0b [3];
	logic signed [PROD_W-1:0] p0_d [3];
	logic signed [PROD_W-1:0] p1_d [3];

	logic                     vld_s1;
	logic [3:0]               mode_s1;
	logic signed [DATA_W-1:0] a_s1 [3];
	logic signed [DATA_W-1:0] b_s1 [3];
	logic signed [PROD_W-1:0] p0_s1 [3];
	logic signed [PROD_W-1:0] p1_s1 [3];

	logic signed [WIDE_W-1:0] w_d [3];
	logic signed [WIDE_W-1:0] sum_d;

	logic                     vld_s2;
	logic [3:0]               mode_s2;
	logic signed [DATA_W-1:0] a_s2 [3];
	logic signed [WIDE_W-1:0] w_s2 [3];
	logic signed [WIDE_W-1:0] sum_s2;

	logic signed [WIDE_W-1:0] dot_w;
	logic [DATA_W:0]          sv [3];
	logic [DATA_W:0]          ss;
	sq_t                      fr_d;
	logic                     vld_s3;
	sq_t                      fr_s3;

	always_comb begin
		av[0] = cmd.a_x;
		av[1] = cmd.a_y;
		av[2] = cmd.a_z;
		bv[0] = cmd.b_x;
		bv[1] = cmd.b_y;
		bv[2] = cmd.b_z;
		for (int i = 0; i < 3; i++) begin
			m0a[i] = av[i];
			m0b[i] = bv[i];
			case (cmd.mode)
				MODE_SCALE: m0b[i] = cmd.scalar_in;
				MODE_RAY: begin
					m0a[i] = bv[i];
					m0b[i] = cmd.scalar_in;
				end
				MODE_LEN, MODE_NORM: m0b[i] = av[i];
				MODE_CROSS: begin
					m0a[i] = av[(i + 1) % 3];
					m0b[i] = bv[(i + 2) % 3];
				end
				default: ;
			endcase
			p0_d[i] = m0a[i] * m0b[i];
			// second cross term only
			p1_d[i] = av[(i + 2) % 3] * bv[(i + 1) % 3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cmd_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= cmd.mode;
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= av[i];
				b_s1[i]  <= bv[i];
				p0_s1[i] <= p0_d[i];
				p1_s1[i] <= p1_d[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (mode_s1)
				MODE_ADD:   w_d[i] = WIDE_W'(a_s1[i]) + WIDE_W'(b_s1[i]);
				MODE_SUB:   w_d[i] = WIDE_W'(a_s1[i]) - WIDE_W'(b_s1[i]);
				MODE_MUL, MODE_SCALE: w_d[i] = WIDE_W'(p0_s1[i]) >>> FRAC_BITS;
				MODE_CROSS: w_d[i] = (WIDE_W'(p0_s1[i]) - WIDE_W'(p1_s1[i])) >>> FRAC_BITS;
				MODE_RAY:   w_d[i] = WIDE_W'(a_s1[i]) + (WIDE_W'(p0_s1[i]) >>> FRAC_BITS);
				default:    w_d[i] = '0;
			endcase
		end
		sum_d = WIDE_W'(p0_s1[0]) + WIDE_W'(p0_s1[1]) + WIDE_W'(p0_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			sum_s2  <= sum_d;
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= a_s1[i];
				w_s2[i] <= w_d[i];
			end
		end
	end

	always_comb begin
		dot_w = sum_s2 >>> FRAC_BITS;
		ss    = sat_word(dot_w);
		for (int i = 0; i < 3; i++) begin
			sv[i] = sat_word(w_s2[i]);
		end
		fr_d      = '0;
		fr_d.kind = KIND_DONE;
		case (mode_s2)
			MODE_ADD, MODE_SUB, MODE_MUL, MODE_SCALE, MODE_CROSS, MODE_RAY: begin
				fr_d.res.res_x     = sv[0][DATA_W-1:0];
				fr_d.res.res_y     = sv[1][DATA_W-1:0];
				fr_d.res.res_z     = sv[2][DATA_W-1:0];
				fr_d.res.saturated = sv[0][DATA_W] | sv[1][DATA_W] | sv[2][DATA_W];
			end
			MODE_DOT: begin
				fr_d.res.res_scalar = ss[DATA_W-1:0];
				fr_d.res.saturated  = ss[DATA_W];
			end
			MODE_LEN:  fr_d.kind = KIND_LEN;
			MODE_NORM: fr_d.kind = KIND_NORM;
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			fr_d.neg[i] = a_s2[i][DATA_W-1];
			fr_d.mag[i] = a_s2[i][DATA_W-1] ? DATA_W'(-a_s2[i]) : DATA_W'(a_s2[i]);
		end
		fr_d.rem  = sum_s2[PROD_W-1:0];
		fr_d.root = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s3 <= fr_d;
		end
	end

	assign fr_vld = vld_s3;
	assign fr     = fr_s3;

endmodule

// ===== rtl/vau_sqrt.sv =====
// Pipelined integer square root, two result bits per stage.
module vau_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          din_vld,
	input  vau_pkg::sq_t  din,
	output logic          dout_vld,
	output vau_pkg::sq_t  dout
);
	import vau_pkg::*;

	logic sq_vld_s [0:SQ_STG];
	sq_t  sq_s [0:SQ_STG];

	assign sq_vld_s[0] = din_vld;
	assign sq_s[0]     = din;

	for (genvar g = 0; g < SQ_STG; g++) begin : g_stage
		logic [PROD_W-1:0] rm;
		logic [PROD_W-1:0] rt;
		logic [PROD_W-1:0] tr;
		logic [PROD_W-1:0] bt;
		sq_t               nxt;

		always_comb begin
			rm = sq_s[g].rem;
			rt = sq_s[g].root;
			bt = '0;
			tr = '0;
			for (int j = 0; j < 2; j++) begin
				bt = PROD_W'(1) << (PROD_W - 2 - 2 * (2 * g + j));
				tr = rt + bt;
				if (rm >= tr) begin
					rm = rm - tr;
					rt = (rt >> 1) + bt;
				end else begin
					rt = rt >> 1;
				end
			end
			nxt      = sq_s[g];
			nxt.rem  = rm;
			nxt.root = rt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[g+1] <= sq_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g+1] <= nxt;
			end
		end
	end

	assign dout_vld = sq_vld_s[SQ_STG];
	assign dout     = sq_s[SQ_STG];

endmodule

// ===== rtl/vau_div.sv =====
// Length finish, normalize divide stages and output register of the vector unit.
module vau_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               din_vld,
	input  vau_pkg::sq_t       din,
	output logic               dout_vld,
	output vau_pkg::out_word_t dout
);
	import vau_pkg::*;

	logic            dv_vld_s [0:DIV_STG];
	dv_t             dv_s [0:DIV_STG];
	dv_t             d0;
	logic [DATA_W:0] ls;
	logic            zero_len;
	logic [DATA_W-1:0] qv [3];
	out_word_t       out_d;
	logic            out_vld_q;
	out_word_t       out_q;

	// finish the length result, seed the dividers with |a|
	always_comb begin
		ls      = sat_word(WIDE_W'(din.root));
		d0      = '0;
		d0.kind = din.kind;
		d0.res  = din.res;
		d0.neg  = din.neg;
		d0.len  = din.root[DATA_W-1:0];
		for (int i = 0; i < 3; i++) begin
			d0.rem[i] = {1'b0, din.mag[i]};
		end
		if (din.kind == KIND_LEN) begin
			d0.res.res_scalar = ls[DATA_W-1:0];
			d0.res.saturated  = ls[DATA_W];
			d0.kind           = KIND_DONE;
		end
	end

	assign dv_vld_s[0] = din_vld;
	assign dv_s[0]     = d0;

	for (genvar g = 0; g < DIV_STG; g++) begin : g_stage
		dv_t  nxt;
		logic ge;

		always_comb begin
			nxt = dv_s[g];
			ge  = 1'b0;
			for (int j = 0; j < 2; j++) begin
				if (2 * g + j < DIV_STEPS) begin
					for (int i = 0; i < 3; i++) begin
						ge = nxt.rem[i] >= {1'b0, nxt.len};
						if (ge) begin
							nxt.rem[i] = nxt.rem[i] - {1'b0, nxt.len};
						end
						nxt.quo[i] = {nxt.quo[i][FRAC_BITS-1:0], ge};
						nxt.rem[i] = {nxt.rem[i][DATA_W-1:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[g+1] <= dv_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[g+1] <= nxt;
			end
		end
	end

	// quotient never exceeds one, so no clamp on the normalized result
	always_comb begin
		zero_len = (dv_s[DIV_STG].len == '0) || (dv_s[DIV_STG].len < EPS_Q);
		for (int i = 0; i < 3; i++) begin
			qv[i] = DATA_W'(dv_s[DIV_STG].quo[i]);
			if (dv_s[DIV_STG].neg[i]) begin
				qv[i] = -qv[i];
			end
		end
		out_d = dv_s[DIV_STG].res;
		if (dv_s[DIV_STG].kind == KIND_NORM && !zero_len) begin
			out_d.res_x = qv[0];
			out_d.res_y = qv[1];
			out_d.res_z = qv[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s[DIV_STG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_d;
		end
	end

	assign dout_vld = out_vld_q;
	assign dout     = out_q;

endmodule
